### rtl/core/tfsp_pkg.sv
// ----------------------------------------------------------------------------
// tfsp_pkg
// Types, codes and the tag decode table of the tagged field stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tfsp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  field_kind;
    logic [63:0] field_value;
    logic [7:0]  string_length;
    logic        field_end;
    logic [1:0]  status;
    logic        payload_end;
  } out_t;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_NUM,
    PH_SLEN,
    PH_SCHR,
    PH_ERR
  } phase_t;

  localparam logic [2:0] KIND_CHAR   = 3'd0;
  localparam logic [2:0] KIND_SHORT  = 3'd1;
  localparam logic [2:0] KIND_INT32  = 3'd2;
  localparam logic [2:0] KIND_FLOAT  = 3'd3;
  localparam logic [2:0] KIND_STRING = 3'd4;
  localparam logic [2:0] KIND_OBJID  = 3'd5;
  localparam logic [2:0] KIND_TIME   = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADTAG  = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;
  localparam logic [1:0] ST_TOOLONG = 2'd3;

  localparam logic [7:0] TAG_CHAR   = 8'h63;  // 'c'
  localparam logic [7:0] TAG_SHORT  = 8'h68;  // 'h'
  localparam logic [7:0] TAG_INT32  = 8'h64;  // 'd'
  localparam logic [7:0] TAG_FLOAT  = 8'h66;  // 'f'
  localparam logic [7:0] TAG_STRING = 8'h73;  // 's'
  localparam logic [7:0] TAG_OBJID  = 8'h6e;  // 'n'
  localparam logic [7:0] TAG_TIME   = 8'h74;  // 't'

  typedef struct packed {
    logic       known;
    logic [2:0] kind;
    logic [7:0] len;
  } tag_info_t;

  function automatic tag_info_t tag_lookup(input logic [7:0] b);
    tag_info_t info;
    info = '0;
    info.known = 1'b1;
    unique case (b)
      TAG_CHAR:   begin info.kind = KIND_CHAR;   info.len = 8'd1; end
      TAG_SHORT:  begin info.kind = KIND_SHORT;  info.len = 8'd2; end
      TAG_INT32:  begin info.kind = KIND_INT32;  info.len = 8'd4; end
      TAG_FLOAT:  begin info.kind = KIND_FLOAT;  info.len = 8'd4; end
      TAG_STRING: begin info.kind = KIND_STRING; info.len = 8'd0; end
      TAG_OBJID:  begin info.kind = KIND_OBJID;  info.len = 8'd8; end
      TAG_TIME:   begin info.kind = KIND_TIME;   info.len = 8'd8; end
      default:    info.known = 1'b0;
    endcase
    return info;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tfsp_step.sv
// ----------------------------------------------------------------------------
// tfsp_step
// Parser state and the single-pass update for one transferred byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsp_step #(
  parameter int MAX_PAYLOAD = 512
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire tfsp_pkg::in_t  in_item,
  output logic              res_valid,
  output tfsp_pkg::out_t    res
);
  import tfsp_pkg::*;

  localparam int OFF_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_PAYLOAD);
  localparam logic [OFF_W-1:0] OFF_ONE = OFF_W'(1);

  phase_t           phase_r, phase_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [7:0]       left_r, left_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [7:0]       held_r, held_nxt;

  logic [7:0]  b;
  logic        last;
  logic        too_long;
  logic [7:0]  left_dec;
  logic [63:0] acc_sh;
  tag_info_t   tag;

  assign b        = in_item.data_byte;
  assign last     = in_item.last_byte;
  assign too_long = (off_r >= OFF_MAX);
  assign left_dec = left_r - {7'd0, (left_r != 8'd0)};
  assign acc_sh   = {acc_r[55:0], b};
  assign tag      = tag_lookup(b);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (phase_r != PH_ERR) begin
      if (too_long) begin
        phase_nxt = PH_ERR;
      end else begin
        unique case (phase_r)
          PH_TAG: begin
            if (!tag.known) phase_nxt = PH_ERR;
            else if (tag.kind == KIND_STRING) phase_nxt = PH_SLEN;
            else phase_nxt = PH_NUM;
          end
          PH_NUM:  if (left_dec == 8'd0) phase_nxt = PH_TAG;
          PH_SLEN: phase_nxt = (b == 8'd0) ? PH_TAG : PH_SCHR;
          PH_SCHR: if (left_dec == 8'd0) phase_nxt = PH_TAG;
          default: phase_nxt = PH_ERR;
        endcase
      end
    end
    if (last) phase_nxt = PH_TAG;
  end

  // datapath and result
  always_comb begin
    kind_nxt  = kind_r;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    off_nxt   = off_r;
    held_nxt  = held_r;
    res_valid = 1'b0;
    res       = '0;
    res.payload_end = last;
    if (phase_r != PH_ERR) begin
      if (too_long) begin
        res_valid  = 1'b1;
        res.status = ST_TOOLONG;
      end else begin
        off_nxt = off_r + OFF_ONE;
        unique case (phase_r)
          PH_TAG: begin
            if (!tag.known) begin
              res_valid       = 1'b1;
              res.status      = ST_BADTAG;
              res.field_value = {56'd0, b};
            end else begin
              kind_nxt = tag.kind;
              acc_nxt  = '0;
              left_nxt = tag.len;
              held_nxt = '0;
              if (last) begin
                res_valid      = 1'b1;
                res.field_kind = tag.kind;
                res.status     = ST_TRUNC;
              end
            end
          end
          PH_NUM: begin
            acc_nxt  = acc_sh;
            left_nxt = left_dec;
            res.field_kind = kind_r;
            if (left_dec == 8'd0) begin
              res_valid       = 1'b1;
              res.field_value = acc_sh;
              res.field_end   = 1'b1;
            end else if (last) begin
              res_valid  = 1'b1;
              res.status = ST_TRUNC;
            end
          end
          PH_SLEN: begin
            held_nxt = b;
            left_nxt = b;
            res.field_kind = KIND_STRING;
            if (b == 8'd0) begin
              res_valid     = 1'b1;
              res.field_end = 1'b1;
            end else if (last) begin
              res_valid         = 1'b1;
              res.string_length = b;
              res.status        = ST_TRUNC;
            end
          end
          PH_SCHR: begin
            left_nxt          = left_dec;
            res_valid         = 1'b1;
            res.field_kind    = KIND_STRING;
            res.field_value   = {56'd0, b};
            res.string_length = held_r;
            res.field_end     = (left_dec == 8'd0);
            if (left_dec != 8'd0 && last) res.status = ST_TRUNC;
          end
          default: ;
        endcase
      end
    end
    // close the payload
    if (last) begin
      kind_nxt = '0;
      left_nxt = '0;
      acc_nxt  = '0;
      off_nxt  = '0;
      held_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      kind_r  <= '0;
      left_r  <= '0;
      acc_r   <= '0;
      off_r   <= '0;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
      off_r   <= off_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tfsp_out_buf.sv
// ----------------------------------------------------------------------------
// tfsp_out_buf
// Result register with a skid entry; stall toward the input is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsp_out_buf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tfsp_pkg::out_t push_data,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tfsp_pkg::out_t      out_data
);
  import tfsp_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t out_data_r, out_data_nxt;
  out_t skid_data_r, skid_data_nxt;
  logic pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // input is stalled; drain the skid entry
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/tagged_field_stream_parser.sv
// ----------------------------------------------------------------------------
// tagged_field_stream_parser
// Tag/length/value stream parser producing one result per field, char or error.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_stall is low; the parser state
// updates in a single pass. A result is registered before it reaches out_data.
// The result register plus one skid entry absorbs out_stall; in_stall is
// raised only while the skid entry holds a result.
// Reset: synchronous active-low rst_n returns the parser to waiting for a tag
// and empties the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_field_stream_parser #(
  parameter int MAX_PAYLOAD = 512
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire tfsp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tfsp_pkg::out_t      out_data
);
  import tfsp_pkg::*;

  logic accept;
  logic res_valid;
  out_t res;
  logic buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  tfsp_step #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_data),
    .res_valid(res_valid),
    .res      (res)
  );

  tfsp_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept && res_valid),
    .push_data(res),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // skid entry only fills behind a held result
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_end_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.field_end) |-> (out_data.status == ST_OK))
    else $error("completed field carries an error status");

  a_len_only_string: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.field_kind != KIND_STRING) |->
      (out_data.string_length == 8'd0))
    else $error("string length on a non-string result");

endmodule

`default_nettype wire
